// File: hw/rtl/tklf_pkg.sv
// Package for the top-k logit filter: widths, payload types and register indexes.
`timescale 1ns / 1ps
package tklf_pkg;

  localparam int FIELDS    = 8;   // logit fields carried by one request
  localparam int LANES_DEF = 8;   // default number of compare lanes
  localparam int LOGIT_W   = 32;
  localparam int CNT_W     = 4;   // keep/active counts, 0..15
  localparam int IDX_W     = 2;   // configuration register index

  typedef logic signed [LOGIT_W-1:0] logit_t;

  typedef struct packed {
    logit_t logit_0;
    logit_t logit_1;
    logit_t logit_2;
    logit_t logit_3;
    logit_t logit_4;
    logit_t logit_5;
    logit_t logit_6;
    logit_t logit_7;
  } logit_vec_t;

  typedef struct packed {
    logit_t             kept_0;
    logit_t             kept_1;
    logit_t             kept_2;
    logit_t             kept_3;
    logit_t             kept_4;
    logit_t             kept_5;
    logit_t             kept_6;
    logit_t             kept_7;
    logic [CNT_W-1:0]   picked_total;
  } kept_vec_t;

  // Selection settings travelling with a request into the merge stage
  typedef struct packed {
    logic [CNT_W-1:0] keep;
    logic [CNT_W-1:0] active;   // already saturated to the lane count
  } sel_cfg_t;

  localparam logic [IDX_W-1:0] REG_KEEP_COUNT   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ACTIVE_COUNT = IDX_W'(1);

endpackage

// File: hw/rtl/tklf_if.sv
// Valid/ready channel interfaces for logit vectors and filtered results.
`timescale 1ns / 1ps
interface tklf_logit_if;
  import tklf_pkg::*;
  logic       valid;
  logic       ready;
  logit_vec_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tklf_kept_if;
  import tklf_pkg::*;
  logic      valid;
  logic      ready;
  kept_vec_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/tklf_lane.sv
// One compare lane: finds which active lanes outrank this lane's logit.
`timescale 1ns / 1ps
module tklf_lane #(
  parameter int LANES = tklf_pkg::LANES_DEF,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  tklf_pkg::logit_t          logits [tklf_pkg::FIELDS],
  input  logic [tklf_pkg::CNT_W-1:0] active,
  output logic [LANES-1:0]          outrank
);
  import tklf_pkg::*;

  logic [LANES-1:0] outrank_next;

  // Higher value wins; on a tie the lower index wins
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      outrank_next[j] = (j != IDX) && (CNT_W'(j) < active) &&
                        ((logits[j] > logits[IDX]) ||
                         ((logits[j] == logits[IDX]) && (j < IDX)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outrank <= outrank_next;
    end
  end

endmodule

// File: hw/rtl/tklf_merge.sv
// Merge stage: counts each lane's outrankers and zeroes lanes that miss the cut.
`timescale 1ns / 1ps
module tklf_merge #(
  parameter int LANES = tklf_pkg::LANES_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  tklf_pkg::logit_t            logits  [tklf_pkg::FIELDS],
  input  logic [LANES-1:0]            outrank [LANES],
  input  tklf_pkg::sel_cfg_t          cfg,
  output tklf_pkg::logit_t            kept    [tklf_pkg::FIELDS],
  output logic [tklf_pkg::CNT_W-1:0]  picked,
  output logic [tklf_pkg::FIELDS-1:0] keep_mask
);
  import tklf_pkg::*;

  logit_t             kept_next [FIELDS];
  logic [CNT_W-1:0]   picked_next;
  logic [FIELDS-1:0]  keep_mask_next;
  logic               filter;

  always_comb begin
    logic [CNT_W-1:0] above;
    logic             lane_on;
    logic             drop;
    filter      = cfg.keep < cfg.active;
    picked_next = filter ? cfg.keep : cfg.active;
    for (int i = 0; i < FIELDS; i++) begin
      kept_next[i]      = logits[i];
      keep_mask_next[i] = 1'b0;
    end
    for (int i = 0; i < LANES; i++) begin
      above = '0;
      for (int j = 0; j < LANES; j++) begin
        above = above + CNT_W'(outrank[i][j]);
      end
      lane_on           = CNT_W'(i) < cfg.active;
      drop              = filter && lane_on && (above >= cfg.keep);
      keep_mask_next[i] = lane_on && !drop;
      kept_next[i]      = drop ? '0 : logits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kept      <= kept_next;
      picked    <= picked_next;
      keep_mask <= keep_mask_next;
    end
  end

endmodule

// File: hw/rtl/top_k_logit_filter_unit.sv
// Top level of the top-k logit filter: config registers, lanes, merge and handshake.
//
//  channel    dir  handshake        carries
//  logit_in   in   valid/ready      logit_0..logit_7, 32-bit signed
//  kept_out   out  valid/ready      kept_0..kept_7, picked_total
//  cfg_*      in   cfg_we only      index 0 keep_count, 1 active_count
//
// Two-stage pipeline, one request per cycle sustained while kept_out is ready.
// Stage 1: the lanes compare their logit with every other active lane
// (LANES-1 32-bit compares per lane). Stage 2: the merge stage counts the
// outrankers per lane and registers the result, which is the output.
// Reset (rst, synchronous) empties both stages and sets both counts to 8.
// A stalled output holds; stage 1 still takes a request while it is empty.
`timescale 1ns / 1ps
module top_k_logit_filter_unit #(
  parameter int LANES = tklf_pkg::LANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tklf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tklf_pkg::CNT_W-1:0]  cfg_data,
  tklf_logit_if.sink                  logit_in,
  tklf_kept_if.source                 kept_out
);
  import tklf_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0] keep_count;
  logic [CNT_W-1:0] active_count;
  logic [CNT_W-1:0] active_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count   <= CNT_W'(8);
      active_count <= CNT_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_COUNT:   keep_count   <= cfg_data;
        REG_ACTIVE_COUNT: active_count <= cfg_data;
        default:          ;  // unknown index, write dropped
      endcase
    end
  end

  // Counts above the lane count act as the lane count
  assign active_eff = (active_count > CNT_W'(LANES)) ? CNT_W'(LANES) : active_count;

  // Pipeline control
  logic s1_valid;
  logic s2_valid;
  logic s1_en;
  logic s2_en;

  assign s2_en          = s1_valid && (!s2_valid || kept_out.ready);
  assign logit_in.ready = !s1_valid || s2_en;
  assign s1_en          = logit_in.valid && logit_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= 1'b1;
      end else if (s2_en) begin
        s1_valid <= 1'b0;
      end
      if (s2_en) begin
        s2_valid <= 1'b1;
      end else if (kept_out.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // Stage 1: unpack the request and run the lanes
  logit_t           in_logits [FIELDS];
  logit_t           s1_logits [FIELDS];
  sel_cfg_t         s1_cfg;
  logic [LANES-1:0] s1_outrank [LANES];

  assign in_logits[0] = logit_in.payload.logit_0;
  assign in_logits[1] = logit_in.payload.logit_1;
  assign in_logits[2] = logit_in.payload.logit_2;
  assign in_logits[3] = logit_in.payload.logit_3;
  assign in_logits[4] = logit_in.payload.logit_4;
  assign in_logits[5] = logit_in.payload.logit_5;
  assign in_logits[6] = logit_in.payload.logit_6;
  assign in_logits[7] = logit_in.payload.logit_7;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_logits     <= in_logits;
      s1_cfg.keep   <= keep_count;
      s1_cfg.active <= active_eff;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tklf_lane #(
      .LANES (LANES),
      .IDX   (g)
    ) u_lane (
      .clk     (clk),
      .en      (s1_en),
      .logits  (in_logits),
      .active  (active_eff),
      .outrank (s1_outrank[g])
    );
  end

  // Stage 2: merge, doubles as the output register
  logit_t            out_logits [FIELDS];
  logic [CNT_W-1:0]  out_picked;
  logic [FIELDS-1:0] out_mask;

  tklf_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .en        (s2_en),
    .logits    (s1_logits),
    .outrank   (s1_outrank),
    .cfg       (s1_cfg),
    .kept      (out_logits),
    .picked    (out_picked),
    .keep_mask (out_mask)
  );

  assign kept_out.valid                = s2_valid;
  assign kept_out.payload.kept_0       = out_logits[0];
  assign kept_out.payload.kept_1       = out_logits[1];
  assign kept_out.payload.kept_2       = out_logits[2];
  assign kept_out.payload.kept_3       = out_logits[3];
  assign kept_out.payload.kept_4       = out_logits[4];
  assign kept_out.payload.kept_5       = out_logits[5];
  assign kept_out.payload.kept_6       = out_logits[6];
  assign kept_out.payload.kept_7       = out_logits[7];
  assign kept_out.payload.picked_total = out_picked;

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !logit_in.ready |-> (s1_valid && s2_valid && !kept_out.ready))
    else $error("input stalled with room in the pipeline");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s1_en |=> s1_valid)
    else $error("accepted request lost in stage 1");

  a_kept_matches_total: assert property (@(posedge clk) disable iff (rst)
    kept_out.valid |-> ($countones(out_mask) == int'(out_picked)))
    else $error("number of kept lanes differs from picked_total");

  a_total_in_range: assert property (@(posedge clk) disable iff (rst)
    kept_out.valid |-> (int'(out_picked) <= LANES))
    else $error("picked_total above lane count");

endmodule
